>>> hdl/cnms_pkg.sv
// Shared types, constants and helper functions for the Canny non-maximum
// suppression block. No dependencies; every other file in hdl/ uses this.
package cnms_pkg;

  // Field and port widths fixed by the stream format
  localparam int MAG_W       = 20;
  localparam int GRAD_W      = 16;
  localparam int GRADS_W     = 2 * GRAD_W;
  localparam int WEIGHT_W    = GRAD_W + 1;
  localparam int ROW_W       = 16;
  localparam int ROWCNT_W    = ROW_W + 1;
  localparam int COLCFG_W    = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  // Bit positions of the input fields inside in_tdata
  localparam int IN_MAG_LSB  = 0;
  localparam int IN_GV_LSB   = MAG_W;
  localparam int IN_GH_LSB   = MAG_W + GRAD_W;

  // Arithmetic widths of the blend and compare path
  localparam int PROD_W      = MAG_W + WEIGHT_W;
  localparam int SUM_W       = PROD_W + 1;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

  // Parameter defaults
  localparam int DEF_MAX_COLUMNS    = 1024;
  localparam int DEF_MAGNITUDE_BITS = 20;

  // Register limits and reset values
  localparam int COLS_MIN   = 3;
  localparam int COLS_RESET = 1024;
  localparam int ROWS_MIN   = 3;
  localparam int ROWS_MAX   = 65535;
  localparam int ROWS_RESET = 1024;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS    = 2'd1;

  // Item kinds carried on in_tuser
  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // One classified pixel: centre, chosen neighbours and blend weights
  typedef struct packed {
    logic                border;
    logic                last;
    logic [MAG_W-1:0]    centre;
    logic [MAG_W-1:0]    near_n;
    logic [MAG_W-1:0]    near_d;
    logic [MAG_W-1:0]    far_n;
    logic [MAG_W-1:0]    far_d;
    logic [WEIGHT_W-1:0] w_big;
    logic [WEIGHT_W-1:0] w_small;
  } work_t;

  // Front to queue
  typedef struct packed {
    logic  push;
    work_t item;
  } push_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic               empty;
    logic [LEVEL_W-1:0] level;
  } q_status_t;

  // Absolute value of a signed gradient, one bit wider so that the most
  // negative code stays exact.
  function automatic logic [WEIGHT_W-1:0] abs_grad(input logic [GRAD_W-1:0] g);
    logic [WEIGHT_W-1:0] ext;
    ext = {g[GRAD_W-1], g};
    return g[GRAD_W-1] ? (WEIGHT_W'(0) - ext) : ext;
  endfunction

  // True when a signed gradient is strictly positive
  function automatic logic grad_pos(input logic [GRAD_W-1:0] g);
    return !g[GRAD_W-1] && (g != '0);
  endfunction

endpackage

>>> hdl/cnms_front.sv
// Front part: raster counters, line buffers, gradient delay, 3x3 window and
// neighbour selection. Depends on cnms_pkg; feeds cnms_queue.
module cnms_front #(
  parameter int MAX_COLUMNS    = cnms_pkg::DEF_MAX_COLUMNS,
  parameter int MAGNITUDE_BITS = cnms_pkg::DEF_MAGNITUDE_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [cnms_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tuser,
  input  logic                                cfg_we,
  input  logic [cnms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cnms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  cnms_pkg::q_status_t                 q_status,
  output cnms_pkg::push_t                     push
);

  localparam int MW  = (MAGNITUDE_BITS < cnms_pkg::MAG_W) ? MAGNITUDE_BITS : cnms_pkg::MAG_W;
  localparam int AW  = $clog2(MAX_COLUMNS);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int KW  = (CW > cnms_pkg::COLCFG_W) ? CW : cnms_pkg::COLCFG_W;
  localparam int RW  = cnms_pkg::ROWCNT_W;
  localparam int GW  = cnms_pkg::GRADS_W;
  localparam int COLS_RST = (cnms_pkg::COLS_RESET < MAX_COLUMNS) ?
                            cnms_pkg::COLS_RESET : MAX_COLUMNS;

  // Configuration and counters
  logic [CW-1:0]              cols_r;
  logic [cnms_pkg::ROW_W-1:0] rows_r;
  logic [AW-1:0]              col_r, col_nxt;
  logic [RW-1:0]              row_r, row_nxt;
  logic [GW-1:0]              hold_r;
  logic                       clr_active_r;
  logic [AW-1:0]              clr_addr_r;

  // Memories and their registered read data
  logic [2*MW-1:0] line_mem [MAX_COLUMNS];
  logic [GW-1:0]   grad_mem [MAX_COLUMNS];
  logic [2*MW-1:0] line_rd_r;
  logic [GW-1:0]   grad_rd_r;

  // First front stage
  logic            f1_v_r;
  logic [AW-1:0]   f1_addr_r;
  logic [MW-1:0]   f1_mag_r;
  logic            f1_produce_r;
  logic            f1_border_r;
  logic            f1_last_r;
  logic            f1_hit_r;
  logic [2*MW-1:0] f1_byp_r;

  logic [MW-1:0] win_r   [3][3];
  logic [MW-1:0] win_new [3][3];

  logic                      accept;
  logic [AW-1:0]             c0;
  logic [AW-1:0]             prev;
  logic                      take;
  logic [MW-1:0]             mag_in;
  logic [GW-1:0]             grads_in;
  logic                      produce;
  logic [RW-1:0]             orow;
  logic [AW-1:0]             ocol;
  logic [RW-1:0]             rows_m1;
  logic [RW-1:0]             rows_p1;
  logic [CW-1:0]             cols_m1;
  logic                      border;
  logic                      last;
  logic                      cfg_restart;
  logic                      line_we;
  logic [AW-1:0]             line_wa;
  logic [2*MW-1:0]           line_wd;
  logic [2*MW-1:0]           line_eff;
  logic [KW-1:0]             cfg_cols_raw;
  logic [CW-1:0]             cfg_cols;
  logic [cnms_pkg::ROW_W-1:0] cfg_rows;
  logic [RW-1:0]             row_inc;

  // Input is taken after the clearing pass, while the queue has room for
  // every item already in flight.
  assign in_tready = !clr_active_r &&
                     ((q_status.level + cnms_pkg::LEVEL_W'(f1_v_r)) <
                      cnms_pkg::LEVEL_W'(cnms_pkg::QUEUE_DEPTH));
  assign accept    = in_tvalid && in_tready;

  // Item decode and output-pixel position
  always_comb begin
    c0       = (KW'(col_r) >= KW'(cols_r)) ? '0 : col_r;
    prev     = (col_r == '0) ? AW'(cols_r - CW'(1)) : (col_r - AW'(1));
    take     = (in_tuser == cnms_pkg::ACT_PIXEL) && (row_r < RW'(rows_r));
    mag_in   = take ? in_tdata[cnms_pkg::IN_MAG_LSB +: MW] : '0;
    grads_in = take ? in_tdata[cnms_pkg::IN_GV_LSB +: GW] : '0;
    rows_m1  = RW'(rows_r) - RW'(1);
    rows_p1  = RW'(rows_r) + RW'(1);
    cols_m1  = cols_r - CW'(1);
    produce  = (row_r >= RW'(2)) || ((row_r == RW'(1)) && (c0 != '0));
    orow     = (c0 != '0) ? (row_r - RW'(1)) : (row_r - RW'(2));
    ocol     = (c0 != '0) ? (c0 - AW'(1)) : AW'(cols_m1);
    border   = (orow == '0) || (orow >= rows_m1) || (ocol == '0) ||
               (CW'(ocol) >= cols_m1);
    last     = (orow == rows_m1) && (CW'(ocol) == cols_m1);
  end

  // Configuration decode with clamping
  always_comb begin
    cfg_cols_raw = KW'(cfg_data[cnms_pkg::COLCFG_W-1:0]);
    if (cfg_cols_raw < KW'(cnms_pkg::COLS_MIN)) begin
      cfg_cols = CW'(cnms_pkg::COLS_MIN);
    end else if (cfg_cols_raw > KW'(MAX_COLUMNS)) begin
      cfg_cols = CW'(MAX_COLUMNS);
    end else begin
      cfg_cols = CW'(cfg_cols_raw);
    end
    if (cfg_data < cnms_pkg::ROW_W'(cnms_pkg::ROWS_MIN)) begin
      cfg_rows = cnms_pkg::ROW_W'(cnms_pkg::ROWS_MIN);
    end else begin
      cfg_rows = cfg_data;
    end
    cfg_restart = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        cnms_pkg::CFG_IDX_COLUMNS: cfg_restart = 1'b1;
        cnms_pkg::CFG_IDX_ROWS:    cfg_restart = 1'b1;
        default:                   cfg_restart = 1'b0;
      endcase
    end
  end

  // Counter advance; the frame's last result and a register write restart
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    row_inc = row_r + RW'(1);
    if (accept) begin
      if (produce && last) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if ((CW'(c0) + CW'(1)) >= cols_r) begin
        col_nxt = '0;
        row_nxt = (row_inc > rows_p1) ? rows_p1 : row_inc;
      end else begin
        col_nxt = c0 + AW'(1);
        row_nxt = (row_r > rows_p1) ? rows_p1 : row_r;
      end
    end
    if (cfg_restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r       <= CW'(COLS_RST);
      rows_r       <= cnms_pkg::ROW_W'(cnms_pkg::ROWS_RESET);
      col_r        <= '0;
      row_r        <= '0;
      hold_r       <= '0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      f1_v_r       <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      f1_v_r <= accept;
      if (accept) begin
        hold_r <= grads_in;
      end
      if (cfg_we && (cfg_index == cnms_pkg::CFG_IDX_COLUMNS)) begin
        cols_r <= cfg_cols;
      end
      if (cfg_we && (cfg_index == cnms_pkg::CFG_IDX_ROWS)) begin
        rows_r <= cfg_rows;
      end
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAX_COLUMNS - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  // Line buffer write: clearing pass, or the shifted pair in the cycle after
  // the read of the same column.
  assign line_eff = f1_hit_r ? f1_byp_r : line_rd_r;
  assign line_we  = clr_active_r || f1_v_r;
  assign line_wa  = clr_active_r ? clr_addr_r : f1_addr_r;
  assign line_wd  = clr_active_r ? '0 : {line_eff[MW-1:0], f1_mag_r};

  // Line buffer memory, word holds the upper row above the middle row
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd_r <= line_mem[c0];
    end
    if (line_we) begin
      line_mem[line_wa] <= line_wd;
    end
  end

  // Gradient delay memory, read before write at the same address
  always_ff @(posedge clk) begin
    if (accept) begin
      grad_rd_r      <= grad_mem[prev];
      grad_mem[prev] <= hold_r;
    end else if (clr_active_r) begin
      grad_mem[clr_addr_r] <= '0;
    end
  end

  // First-stage payload, with a bypass when the pending write hits the read
  always_ff @(posedge clk) begin
    if (accept) begin
      f1_addr_r    <= c0;
      f1_mag_r     <= mag_in;
      f1_produce_r <= produce;
      f1_border_r  <= border;
      f1_last_r    <= last;
      f1_hit_r     <= line_we && (line_wa == c0);
      f1_byp_r     <= line_wd;
    end
  end

  // Window shift with the new column from the line buffers
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_new[k][0] = win_r[k][1];
      win_new[k][1] = win_r[k][2];
    end
    win_new[0][2] = line_eff[2*MW-1:MW];
    win_new[1][2] = line_eff[MW-1:0];
    win_new[2][2] = f1_mag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= '0;
        end
      end
    end else if (f1_v_r) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[k][j] <= win_new[k][j];
        end
      end
    end
  end

  // Dominant axis and neighbour choice from the gradient signs
  logic [cnms_pkg::GRAD_W-1:0]   gv, gh;
  logic                          gv_pos, gh_pos;
  logic [cnms_pkg::WEIGHT_W-1:0] ax, ay;
  logic [MW-1:0]                 h_near, h_far, v_near, v_far, diag_near, diag_far;

  always_comb begin
    gv        = grad_rd_r[cnms_pkg::GRAD_W-1:0];
    gh        = grad_rd_r[GW-1:cnms_pkg::GRAD_W];
    gv_pos    = cnms_pkg::grad_pos(gv);
    gh_pos    = cnms_pkg::grad_pos(gh);
    ax        = cnms_pkg::abs_grad(gv);
    ay        = cnms_pkg::abs_grad(gh);
    h_near    = gv_pos ? win_new[1][0] : win_new[1][2];
    h_far     = gv_pos ? win_new[1][2] : win_new[1][0];
    v_near    = gh_pos ? win_new[0][1] : win_new[2][1];
    v_far     = gh_pos ? win_new[2][1] : win_new[0][1];
    diag_near = gh_pos ? (gv_pos ? win_new[0][0] : win_new[0][2])
                       : (gv_pos ? win_new[2][0] : win_new[2][2]);
    diag_far  = gh_pos ? (gv_pos ? win_new[2][2] : win_new[2][0])
                       : (gv_pos ? win_new[0][2] : win_new[0][0]);

    push.push        = f1_v_r && f1_produce_r;
    push.item.border = f1_border_r;
    push.item.last   = f1_last_r;
    push.item.centre = cnms_pkg::MAG_W'(win_new[1][1]);
    push.item.near_d = cnms_pkg::MAG_W'(diag_near);
    push.item.far_d  = cnms_pkg::MAG_W'(diag_far);
    if (ax > ay) begin
      push.item.near_n  = cnms_pkg::MAG_W'(h_near);
      push.item.far_n   = cnms_pkg::MAG_W'(h_far);
      push.item.w_big   = ax;
      push.item.w_small = ay;
    end else begin
      push.item.near_n  = cnms_pkg::MAG_W'(v_near);
      push.item.far_n   = cnms_pkg::MAG_W'(v_far);
      push.item.w_big   = ay;
      push.item.w_small = ax;
    end
  end

endmodule

>>> hdl/cnms_queue.sv
// Short register queue of classified pixels between front and back.
// Depends on cnms_pkg for the item type and depth.
module cnms_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  cnms_pkg::push_t     push,
  input  logic                pop,
  output cnms_pkg::work_t     head,
  output cnms_pkg::q_status_t q_status
);

  cnms_pkg::work_t                 mem_r [cnms_pkg::QUEUE_DEPTH];
  logic [cnms_pkg::PTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [cnms_pkg::LEVEL_W-1:0]    level_r, level_nxt;

  // Fill level follows the two transfers
  always_comb begin
    case ({push.push, pop})
      2'b10:   level_nxt = level_r + cnms_pkg::LEVEL_W'(1);
      2'b01:   level_nxt = level_r - cnms_pkg::LEVEL_W'(1);
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push.push) begin
        wr_ptr_r <= wr_ptr_r + cnms_pkg::PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cnms_pkg::PTR_W'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push.push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  assign head           = mem_r[rd_ptr_r];
  assign q_status.level = level_r;
  assign q_status.empty = (level_r == '0);

endmodule

>>> hdl/cnms_back.sv
// Back part: weighted blends, centre scaling, suppression compare and the
// output register. Depends on cnms_pkg; takes items from cnms_queue.
module cnms_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cnms_pkg::work_t                    head,
  input  cnms_pkg::q_status_t                q_status,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [cnms_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser,
  output logic                               out_tlast
);

  localparam int PW = cnms_pkg::PROD_W;
  localparam int SW = cnms_pkg::SUM_W;

  logic                       adv;
  logic                       b1_v_r;
  logic [PW-1:0]              p_near_n_r, p_near_d_r, p_far_n_r, p_far_d_r, p_centre_r;
  logic                       b1_border_r, b1_last_r;
  logic [cnms_pkg::MAG_W-1:0] b1_centre_r;
  logic                       out_v_r;
  logic [cnms_pkg::MAG_W-1:0] out_mag_r;
  logic                       out_kept_r, out_last_r;

  logic [cnms_pkg::WEIGHT_W-1:0] w_diff;
  logic [SW-1:0]                 near_sum, far_sum, centre_sc;
  logic                          kept;

  // The pipe moves whenever the output register is free or being emptied
  assign adv    = !out_v_r || out_tready;
  assign pop    = adv && !q_status.empty;
  assign w_diff = head.w_big - head.w_small;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b1_v_r  <= pop;
      out_v_r <= b1_v_r;
    end
  end

  // Products of neighbours and weights
  always_ff @(posedge clk) begin
    if (adv) begin
      p_near_n_r  <= PW'(w_diff) * PW'(head.near_n);
      p_near_d_r  <= PW'(head.w_small) * PW'(head.near_d);
      p_far_n_r   <= PW'(w_diff) * PW'(head.far_n);
      p_far_d_r   <= PW'(head.w_small) * PW'(head.far_d);
      p_centre_r  <= PW'(head.w_big) * PW'(head.centre);
      b1_border_r <= head.border;
      b1_last_r   <= head.last;
      b1_centre_r <= head.centre;
    end
  end

  // Keep the centre if it lies on the border, or if it beats the far blend and meets the near blend
  always_comb begin
    near_sum  = SW'(p_near_n_r) + SW'(p_near_d_r);
    far_sum   = SW'(p_far_n_r) + SW'(p_far_d_r);
    centre_sc = SW'(p_centre_r);
    kept      = b1_border_r || ((centre_sc > far_sum) && (centre_sc >= near_sum));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mag_r  <= kept ? b1_centre_r : '0;
      out_kept_r <= kept;
      out_last_r <= b1_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = cnms_pkg::OUT_TDATA_W'(out_mag_r);
  assign out_tuser  = out_kept_r;
  assign out_tlast  = out_last_r;

endmodule

>>> hdl/canny_nonmax_suppression.sv
// Top level of the Canny non-maximum suppression block.
// Depends on cnms_pkg, cnms_front, cnms_queue and cnms_back.
//
// Usage: pixels enter in raster order on the in_ stream, one per transfer.
// A frame is rows*columns pixel items followed by columns+1 flush items
// (in_tuser high). The result for a pixel is produced by the item that
// arrives one row plus one pixel later, so the first columns+1 items of a
// frame give no result and every later item gives exactly one on the out_
// stream; out_tlast marks the frame's final pixel, out_tuser says the pixel
// survived or lies on the border.
// Throughput is one item per cycle while the receiver keeps up: the line
// buffers and gradient delay are single memories with one read and one
// write per item. A result reaches out_tvalid through the first front
// stage (window and select), the queue, the product registers (multiply)
// and the output register (compare). After reset the block clears its
// buffers with in_tready low; configuration writes are taken at any time
// and restart the frame. When the receiver stalls, the output register and
// the four-entry queue fill and in_tready drops; nothing is lost.
module canny_nonmax_suppression #(
  parameter int MAX_COLUMNS    = cnms_pkg::DEF_MAX_COLUMNS,
  parameter int MAGNITUDE_BITS = cnms_pkg::DEF_MAGNITUDE_BITS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Fields from bit 0: magnitude[19:0], gradient_v[35:20], gradient_h[51:36]
  input  logic [cnms_pkg::IN_TDATA_W-1:0]    in_tdata,
  // Fields from bit 0: action
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // Fields from bit 0: suppressed_magnitude[19:0]
  output logic [cnms_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Fields from bit 0: edge_kept
  output logic                               out_tuser,
  output logic                               out_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [cnms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cnms_pkg::CFG_DATA_W-1:0]    cfg_data
);

  cnms_pkg::push_t     push_s;
  cnms_pkg::work_t     head_s;
  cnms_pkg::q_status_t q_status_s;
  logic                pop_s;

  // Front: counters, buffers, window and classification
  cnms_front #(
    .MAX_COLUMNS    (MAX_COLUMNS),
    .MAGNITUDE_BITS (MAGNITUDE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_status  (q_status_s),
    .push      (push_s)
  );

  // Queue between the two halves
  cnms_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_s),
    .pop      (pop_s),
    .head     (head_s),
    .q_status (q_status_s)
  );

  // Back: blends, compare and output register
  cnms_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head_s),
    .q_status   (q_status_s),
    .pop        (pop_s),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // The front never pushes into a full queue
  assert property (@(posedge clk) disable iff (!rst_n)
    push_s.push |->
      ((q_status_s.level < cnms_pkg::LEVEL_W'(cnms_pkg::QUEUE_DEPTH)) || pop_s))
    else $error("queue overflow");

  // The back only takes from a queue that holds an item
  assert property (@(posedge clk) disable iff (!rst_n)
    pop_s |-> !q_status_s.empty)
    else $error("queue underflow");

  // A suppressed pixel always leaves as zero magnitude
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[cnms_pkg::MAG_W-1:0] == '0))
    else $error("suppressed pixel with non-zero magnitude");

endmodule

>>> tb/sv/canny_nms_checker.sv
`timescale 1ns / 100ps
// Result checker for the Canny non-maximum suppression block: it watches the
// pixel, result and register ports, predicts every result and compares it.
// Depends on cnms_pkg for field widths, item kinds and register indexes.
module canny_nms_checker
  import cnms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  input  logic                   out_tlast,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatch_count,
  output int                     results_outstanding,
  output int                     results_checked
);

  localparam int LINE_DEPTH = DEF_MAX_COLUMNS;

  typedef struct packed {
    logic [MAG_W-1:0] magnitude;
    logic             edge_kept;
    logic             last_of_frame;
  } nms_result_t;

  // Shadow copy of the line buffers, window and frame position
  logic [MAG_W-1:0]   line_upper  [LINE_DEPTH];
  logic [MAG_W-1:0]   line_middle [LINE_DEPTH];
  logic [GRADS_W-1:0] grad_line   [LINE_DEPTH];
  logic [MAG_W-1:0]   win [3][3];
  logic [GRADS_W-1:0] grad_hold;
  int unsigned        col_pos, row_pos, width, height;
  nms_result_t        expected_q[$];

  // Counts a wrong field and reports the first few in detail.
  task automatic flag_field(input string field, input longint unsigned want,
                            input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("Mismatch at result %0d, %s: expected %0h, got %0h",
               results_checked, field, want, got);
  endtask

  // Advances the window by one item and queues the result it completes, if any.
  task automatic predict_suppression(input logic action,
                                     input logic [IN_TDATA_W-1:0] data);
    int unsigned              c, r, prev, orow, ocol;
    logic                     take, border, kept, last;
    logic [MAG_W-1:0]         mag;
    logic [GRADS_W-1:0]       grads, centre_grads;
    logic signed [GRAD_W-1:0] gv, gh;
    longint unsigned          ax, ay, big, lesser, n1, d1, n2, d2;
    longint unsigned          near_blend, far_blend, centre_scaled;
    int                       ox, oy;
    nms_result_t              res;
    c = col_pos;
    r = row_pos;
    // Pixels in the drain are dropped, flushes in the pixel part count as blanks.
    take = (action == ACT_PIXEL) && (r < height);
    mag = take ? data[IN_MAG_LSB +: MAG_W] : '0;
    grads = take ? {data[IN_GH_LSB +: GRAD_W], data[IN_GV_LSB +: GRAD_W]} : '0;
    prev = (c == 0) ? width - 1 : c - 1;
    if (c >= width) c = 0;

    // Shift the window and rotate the line buffers.
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = line_upper[c];
    win[1][2] = line_middle[c];
    win[2][2] = mag;
    line_upper[c] = line_middle[c];
    line_middle[c] = mag;

    // The gradients of the window centre come out of the delay line.
    centre_grads = grad_line[prev];
    grad_line[prev] = grad_hold;
    grad_hold = grads;

    if (r >= 2 || (r == 1 && c >= 1)) begin
      orow = (c >= 1) ? r - 1 : r - 2;
      ocol = (c >= 1) ? c - 1 : width - 1;
      border = (orow == 0) || (orow >= height - 1) || (ocol == 0) || (ocol >= width - 1);
      gv = centre_grads[GRAD_W-1:0];
      gh = centre_grads[GRADS_W-1:GRAD_W];
      ax = (gv < 0) ? longint'(-int'(gv)) : longint'(int'(gv));
      ay = (gh < 0) ? longint'(-int'(gh)) : longint'(int'(gh));
      ox = (gv > 0) ? -1 : 1;
      oy = (gh > 0) ? 1 : -1;
      // Pick the neighbour pairs along the dominant gradient axis.
      if (ax > ay) begin
        n1 = win[1][1 + ox];
        d1 = win[1 - oy][1 + ox];
        n2 = win[1][1 - ox];
        d2 = win[1 + oy][1 - ox];
        big = ax;
        lesser = ay;
      end else begin
        n1 = win[1 - oy][1];
        d1 = win[1 - oy][1 + ox];
        n2 = win[1 + oy][1];
        d2 = win[1 + oy][1 - ox];
        big = ay;
        lesser = ax;
      end
      near_blend = (big - lesser) * n1 + lesser * d1;
      far_blend = (big - lesser) * n2 + lesser * d2;
      centre_scaled = longint'(win[1][1]) * big;
      kept = border || (centre_scaled > far_blend && centre_scaled >= near_blend);
      last = (orow == height - 1) && (ocol == width - 1);
      res.magnitude = kept ? win[1][1] : '0;
      res.edge_kept = kept;
      res.last_of_frame = last;
      expected_q.push_back(res);
      if (last) begin
        col_pos = 0;
        row_pos = 0;
        return;
      end
    end

    c++;
    if (c >= width) begin
      c = 0;
      r++;
    end
    if (r > height + 1) r = height + 1;
    col_pos = c;
    row_pos = r;
  endtask

  // Results are checked before the item of the same edge is predicted, since
  // no item can produce a result at the edge of its own transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LINE_DEPTH; i++) begin
        line_upper[i] = '0;
        line_middle[i] = '0;
        grad_line[i] = '0;
      end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          win[i][j] = '0;
      grad_hold = '0;
      col_pos = 0;
      row_pos = 0;
      width = COLS_RESET;
      height = ROWS_RESET;
      expected_q.delete();
      mismatch_count = 0;
      results_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          flag_field("result with nothing expected, tdata", 0, out_tdata);
        end else begin
          if (out_tdata !== OUT_TDATA_W'(expected_q[0].magnitude))
            flag_field("suppressed magnitude", expected_q[0].magnitude, out_tdata);
          if (out_tuser !== expected_q[0].edge_kept)
            flag_field("edge kept", expected_q[0].edge_kept, out_tuser);
          if (out_tlast !== expected_q[0].last_of_frame)
            flag_field("last of frame", expected_q[0].last_of_frame, out_tlast);
          void'(expected_q.pop_front());
        end
        results_checked++;
      end

      // A write to either frame register clamps the value and restarts the frame.
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_COLUMNS) begin
          width = cfg_data[COLCFG_W-1:0];
          if (width < COLS_MIN) width = COLS_MIN;
          if (width > DEF_MAX_COLUMNS) width = DEF_MAX_COLUMNS;
          col_pos = 0;
          row_pos = 0;
        end else if (cfg_index == CFG_IDX_ROWS) begin
          height = (cfg_data < ROWS_MIN) ? ROWS_MIN : cfg_data;
          col_pos = 0;
          row_pos = 0;
        end
      end

      if (in_tvalid && in_tready) predict_suppression(in_tuser, in_tdata);
    end
    results_outstanding <= expected_q.size();
  end

endmodule

>>> tb/sv/canny_nonmax_suppression_tb.sv
`timescale 1ns / 100ps
// Top of the testbench for canny_nonmax_suppression: clock, reset, pixel and
// register stimulus, random stalls, and the verdict. Depends on cnms_pkg,
// the block itself and canny_nms_checker.
module canny_nonmax_suppression_tb;
  import cnms_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;
  localparam int RANDOM_ITEMS = 850;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT = 600000;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = ACT_PIXEL;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser, out_tlast, out_tvalid;
  logic                   out_tready = 1'b0;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int  mismatch_count, results_outstanding, results_checked;
  int  cycle_count = 0;
  int  items_sent = 0;
  int  frame_cols = COLS_RESET;
  int  frame_rows = ROWS_RESET;
  bit  in_steady = 1'b0;
  bit  out_steady = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  canny_nonmax_suppression DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  canny_nms_checker nms_check (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tdata            (in_tdata),
    .in_tuser            (in_tuser),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .out_tlast           (out_tlast),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding),
    .results_checked     (results_checked)
  );

  // Small or extreme magnitudes half of the time, so that ties between centre and blends occur.
  function automatic logic [MAG_W-1:0] random_magnitude();
    case ($urandom_range(0, 3))
      0:       return MAG_W'($urandom_range(0, 7));
      1:       return $urandom_range(0, 1) ? '1 : '0;
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // Gradients near zero give equal weights and zero weights often.
  function automatic logic [GRAD_W-1:0] random_gradient();
    case ($urandom_range(0, 3))
      0: return GRAD_W'(int'($urandom_range(0, 8)) - 4);
      1: case ($urandom_range(0, 3))
           0:       return 16'h8000;
           1:       return 16'h7FFF;
           2:       return 16'hFFFF;
           default: return 16'h0000;
         endcase
      default: return GRAD_W'($urandom);
    endcase
  endfunction

  // One transfer on the pixel channel after a random gap.
  task automatic send_item(input logic action, input logic [MAG_W-1:0] mag,
                           input logic [GRAD_W-1:0] gv, input logic [GRAD_W-1:0] gh);
    int gap;
    gap = in_steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'({gh, gv, mag});
    in_tuser <= action;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // One register write; the local copy of the frame size keeps the stimulus
  // shaped to whole frames.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_COLUMNS) begin
      frame_cols = value[COLCFG_W-1:0];
      if (frame_cols < COLS_MIN) frame_cols = COLS_MIN;
      if (frame_cols > DEF_MAX_COLUMNS) frame_cols = DEF_MAX_COLUMNS;
    end else if (idx == CFG_IDX_ROWS) begin
      frame_rows = (value < ROWS_MIN) ? ROWS_MIN : value;
    end
  endtask

  // Waits until every expected result has arrived, then lets the pipeline
  // settle, since items that produce nothing may still be in flight.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver side: a random stall before each result transfer.
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      stall = out_steady ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int               phase, count, pixels, random_items;
    logic             act;
    logic [MAG_W-1:0] mag;
    logic [GRAD_W-1:0] gv, gh;
    random_items = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed frame of four columns by three rows (a zero write clamps to
    // three): extreme magnitudes and gradients, zero gradients, a flush inside
    // the pixel part and a pixel inside the drain.
    write_register(CFG_IDX_COLUMNS, 16'd4);
    write_register(CFG_IDX_ROWS, 16'd0);
    for (int i = 0; i < 17; i++) begin
      act = (i >= 12) ? ACT_FLUSH : ACT_PIXEL;
      if (i == 7 || i == 14) act = ~act;
      case (i % 3)
        0:       mag = '1;
        1:       mag = '0;
        default: mag = random_magnitude();
      endcase
      case (i % 4)
        0: begin
          gv = 16'h8000;
          gh = 16'h7FFF;
        end
        1: begin
          gv = 16'h7FFF;
          gh = 16'h8000;
        end
        2: begin
          gv = '0;
          gh = '0;
        end
        default: begin
          gv = random_gradient();
          gh = random_gradient();
        end
      endcase
      send_item(act, mag, gv, gh);
    end
    drain_results();

    // Writes to the unused indexes must leave the frame alone.
    write_register(CFG_IDX_SPARE_A, CFG_DATA_W'($urandom));
    write_register(CFG_IDX_SPARE_B, CFG_DATA_W'($urandom));

    // Random frames, mostly well formed, some cut short, with a little noise.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      in_steady = ($urandom_range(0, 3) == 0);
      out_steady = ($urandom_range(0, 3) == 0);
      if (phase == 2) begin
        // Widest rows with all register data bits set: only the opening
        // items of the frame, the next write restarts it.
        write_register(CFG_IDX_COLUMNS, 16'hFFFF);
        write_register(CFG_IDX_ROWS, 16'd3);
        count = $urandom_range(30, 60);
      end else if (phase == 5) begin
        // Tallest frame: only its first rows, the next write restarts it.
        write_register(CFG_IDX_COLUMNS, 16'd3);
        write_register(CFG_IDX_ROWS, 16'hFFFF);
        count = $urandom_range(30, 60);
      end else begin
        if (frame_cols > 12 || $urandom_range(0, 3) != 0)
          write_register(CFG_IDX_COLUMNS,
                         {5'($urandom), COLCFG_W'($urandom_range(0, 12))});
        if (frame_rows > 6 || $urandom_range(0, 3) != 0)
          write_register(CFG_IDX_ROWS, CFG_DATA_W'($urandom_range(0, 6)));
        if ($urandom_range(0, 7) == 0)
          write_register($urandom_range(0, 1) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                         CFG_DATA_W'($urandom));
        count = frame_rows * frame_cols + frame_cols + 1;
        if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count - 1);
      end
      pixels = frame_rows * frame_cols;
      for (int i = 0; i < count; i++) begin
        act = (i < pixels) ? ACT_PIXEL : ACT_FLUSH;
        if ($urandom_range(0, 15) == 0) act = ~act;
        send_item(act, random_magnitude(), random_gradient(), random_gradient());
      end
      random_items += count;
      drain_results();
      phase++;
    end

    $display("Covered %0d pixel transfers over %0d frame settings, from 3x3 frames",
             items_sent, phase + 1);
    $display("up to 1024-pixel rows and 65535-row frames; %0d results compared.",
             results_checked);
    if (mismatch_count == 0 && results_outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
